>>> src/lis_pkg.sv
// Shared types and constants for the longest increasing subsequence block.
// Depends on nothing; only longest_increasing_subsequence.sv refers to it, by scoped names.
package lis_pkg;

   localparam int unsigned CAPACITY_DEF = 64;
   localparam int unsigned OUT_LEN_W    = 7;

   typedef struct packed {
      logic signed [31:0] value;
      logic               start_new;
   } req_type;

   typedef struct packed {
      logic [OUT_LEN_W-1:0] length_here;
      logic [OUT_LEN_W-1:0] best_so_far;
      logic                 dropped;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_WAIT,
      ST_WRITE,
      ST_DONE
   } state_type;

endpackage

>>> src/lis_mem.sv
// Entry store holding each sequence value with its subsequence length.
// One write port and one registered read port; no package dependency.
module lis_mem #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned LW    = 7
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic signed [31:0]               wr_value,
   input  logic [LW-1:0]                    wr_length,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic                             rd_valid_ff,
   output logic signed [31:0]               rd_value_ff,
   output logic [LW-1:0]                    rd_length_ff
);

   logic signed [31:0] value_mem [DEPTH];
   logic [LW-1:0]      length_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         value_mem[wr_addr]  <= wr_value;
         length_mem[wr_addr] <= wr_length;
      end
      if (rd_en) begin
         rd_value_ff  <= value_mem[rd_addr];
         rd_length_ff <= length_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= rd_en;
      end
   end

endmodule

>>> src/lis_cmp.sv
// Compare unit: tracks the longest length among stored entries below the key.
// Fed one entry per cycle by the store; no package dependency.
module lis_cmp #(
   parameter int unsigned LW = 7
) (
   input  logic               clock,
   input  logic               clear,
   input  logic               sample_en,
   input  logic signed [31:0] sample_value,
   input  logic [LW-1:0]      sample_length,
   input  logic signed [31:0] key,
   output logic [LW-1:0]      longest_ff
);

   logic          hit;
   logic [LW-1:0] longest_in;

   assign hit = sample_en && (sample_value < key) && (sample_length > longest_ff);

   always_comb begin
      if (clear) begin
         longest_in = '0;
      end else if (hit) begin
         longest_in = sample_length;
      end else begin
         longest_in = longest_ff;
      end
   end

   always_ff @(posedge clock) begin
      longest_ff <= longest_in;
   end

endmodule

>>> src/longest_increasing_subsequence.sv
// After its transfer an item passes through check, a scan of the stored entries,
// wait, write and done; a full store goes from check to done, an empty one skips
// scan and wait. A new item is taken only once done is left for idle; the scan reads
// one entry per cycle through the single read port of the store and the compare unit.
// Reset clears the sequencer, the entry count, the best length and the result valid
// flag; the store itself needs no clearing pass. Depends on lis_pkg.
module longest_increasing_subsequence #(
   parameter int unsigned CAPACITY = lis_pkg::CAPACITY_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lis_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lis_pkg::rsp_type rsp_payload
);

   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned AW = $clog2(CAPACITY);

   lis_pkg::state_type state_ff, state_in;

   logic signed [31:0] key_ff, key_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      best_ff, best_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic [6:0]         res_len_ff, res_len_in;
   logic [6:0]         res_best_ff, res_best_in;
   logic               res_drop_ff, res_drop_in;
   logic               rsp_valid_ff, rsp_valid_in;
   lis_pkg::rsp_type   rsp_ff;

   logic               req_xfer;
   logic               rsp_free;
   logic               rsp_load;
   logic               full;
   logic               last;
   logic               rd_en;
   logic               wr_en;
   logic               cmp_clear;
   logic               rd_valid;
   logic signed [31:0] rd_value;
   logic [CW-1:0]      rd_length;
   logic [CW-1:0]      longest;
   logic [CW-1:0]      here;
   logic [CW+6:0]      here_ext;
   logic [CW+6:0]      best_ext;
   logic [CW+6:0]      best_in_ext;

   assign req_xfer    = req_valid && !req_stall;
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign full        = (count_ff == CW'(CAPACITY));
   assign last        = (CW'(idx_ff) == (count_ff - CW'(1)));
   assign here        = longest + CW'(1);
   assign here_ext    = {7'd0, here};
   assign best_ext    = {7'd0, best_ff};
   assign best_in_ext = {7'd0, best_in};

   lis_mem #(
      .DEPTH (CAPACITY),
      .LW    (CW)
   ) u_mem (
      .clock        (clock),
      .reset        (reset),
      .wr_en        (wr_en),
      .wr_addr      (count_ff[AW-1:0]),
      .wr_value     (key_ff),
      .wr_length    (here),
      .rd_en        (rd_en),
      .rd_addr      (idx_ff),
      .rd_valid_ff  (rd_valid),
      .rd_value_ff  (rd_value),
      .rd_length_ff (rd_length)
   );

   lis_cmp #(
      .LW (CW)
   ) u_cmp (
      .clock         (clock),
      .clear         (cmp_clear),
      .sample_en     (rd_valid),
      .sample_value  (rd_value),
      .sample_length (rd_length),
      .key           (key_ff),
      .longest_ff    (longest)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lis_pkg::ST_IDLE: begin
            if (req_xfer) begin
               state_in = lis_pkg::ST_CHECK;
            end
         end
         lis_pkg::ST_CHECK: begin
            if (full) begin
               state_in = lis_pkg::ST_DONE;
            end else if (count_ff == '0) begin
               state_in = lis_pkg::ST_WRITE;
            end else begin
               state_in = lis_pkg::ST_SCAN;
            end
         end
         lis_pkg::ST_SCAN: begin
            if (last) begin
               state_in = lis_pkg::ST_WAIT;
            end
         end
         lis_pkg::ST_WAIT: begin
            state_in = lis_pkg::ST_WRITE;
         end
         lis_pkg::ST_WRITE: begin
            state_in = lis_pkg::ST_DONE;
         end
         lis_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = lis_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lis_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      key_in      = key_ff;
      count_in    = count_ff;
      best_in     = best_ff;
      idx_in      = idx_ff;
      res_len_in  = res_len_ff;
      res_best_in = res_best_ff;
      res_drop_in = res_drop_ff;
      req_stall   = 1'b1;
      rd_en       = 1'b0;
      wr_en       = 1'b0;
      cmp_clear   = 1'b0;
      rsp_load    = 1'b0;
      unique case (state_ff)
         lis_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_xfer) begin
               key_in = req_payload.value;
               if (req_payload.start_new) begin
                  count_in = '0;
                  best_in  = '0;
               end
            end
         end
         lis_pkg::ST_CHECK: begin
            idx_in    = '0;
            cmp_clear = 1'b1;
            if (full) begin
               res_len_in  = '0;
               res_best_in = best_ext[6:0];
               res_drop_in = 1'b1;
            end
         end
         lis_pkg::ST_SCAN: begin
            rd_en  = 1'b1;
            idx_in = idx_ff + AW'(1);
         end
         lis_pkg::ST_WAIT: begin
         end
         lis_pkg::ST_WRITE: begin
            wr_en    = 1'b1;
            count_in = count_ff + CW'(1);
            if (here > best_ff) begin
               best_in = here;
            end
            res_len_in  = here_ext[6:0];
            res_best_in = best_in_ext[6:0];
            res_drop_in = 1'b0;
         end
         lis_pkg::ST_DONE: begin
            rsp_load = rsp_free;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lis_pkg::ST_IDLE;
         count_ff     <= '0;
         best_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         best_ff      <= best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      idx_ff      <= idx_in;
      res_len_ff  <= res_len_in;
      res_best_ff <= res_best_in;
      res_drop_ff <= res_drop_in;
      if (rsp_load) begin
         rsp_ff.length_here <= res_len_ff;
         rsp_ff.best_so_far <= res_best_ff;
         rsp_ff.dropped     <= res_drop_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // The scan only runs over a non-empty store.
   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lis_pkg::ST_SCAN) |-> (count_ff != '0))
      else $error("scan started on an empty store");

   // The entry count never passes the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count exceeds capacity");

   // The best length can never exceed the number of stored entries.
   a_best_bound: assert property (@(posedge clock) disable iff (reset)
      best_ff <= count_ff)
      else $error("best length exceeds entry count");

   // The longest length below the key comes from an entry already stored.
   a_longest_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lis_pkg::ST_WRITE) |-> (longest <= count_ff))
      else $error("longest length below key exceeds entry count");

   // Each write of an entry adds exactly one to the count.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lis_pkg::ST_WRITE) |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("entry count did not advance after a write");

   // A result is never loaded while a previous one is still stalled.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !rsp_load)
      else $error("result register overwritten while stalled");

endmodule
